@@ design/tcw_pkg.sv @@
// Shared constants, types and codes for the text console writer.
package tcw_pkg;

  // Screen geometry
  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;

  // Fixed field widths
  localparam int OP_W   = 2;
  localparam int CHAR_W = 8;
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int OFF_W  = 11;
  localparam int CELL_W = 16;
  localparam int ATTR_W = 8;
  localparam int CFG_IDX_W = 2;

  // Derived storage widths
  localparam int ADDR_W = $clog2(CELLS);
  localparam int TOP_W  = $clog2(ROWS);

  // Queue depth between stages (power of two)
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Operation codes
  localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CHAR_COLOR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERSE    = 2'd1;

  // Character and attribute constants
  localparam logic [CHAR_W-1:0] NEWLINE_CODE  = 8'h0A;
  localparam logic [CHAR_W-1:0] SPACE_CODE    = 8'h20;
  localparam logic [ATTR_W-1:0] BLANK_NORMAL  = 8'h07;
  localparam logic [ATTR_W-1:0] BLANK_INVERSE = 8'h70;
  localparam logic [ATTR_W-1:0] COLOR_RESET   = 8'h0E;

  // Classified command passed from front to back
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [CHAR_W-1:0] char_code;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic              newline;
    logic              in_range;
  } cmd_t;

  // One result transaction
  typedef struct packed {
    logic [COL_W-1:0]  cursor_col;
    logic [ROW_W-1:0]  cursor_row;
    logic [OFF_W-1:0]  cursor_offset;
    logic [CELL_W-1:0] cell_value;
    logic              scrolled;
  } res_t;

endpackage

@@ design/tcw_front.sv @@
// Front end: accept and classify input transactions into a short command queue.
module tcw_front
  import tcw_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic              hold,
  output logic              full,
  input  logic [OP_W-1:0]   op,
  input  logic [CHAR_W-1:0] char_code,
  input  logic [ROW_W-1:0]  row,
  input  logic [COL_W-1:0]  col,
  input  logic              cmd_pop,
  output logic              cmd_empty,
  output cmd_t              cmd_head
);

  cmd_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  cmd_t              cmd_in;
  logic              do_push;
  logic              do_pop;

  assign full      = (count == QCNT_W'(QDEPTH)) || hold;
  assign cmd_empty = (count == '0);
  assign cmd_head  = slots[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = cmd_pop && !cmd_empty;

  // Classify: flag newline and read range once, here
  always_comb begin
    cmd_in.op        = op;
    cmd_in.char_code = char_code;
    cmd_in.row       = row;
    cmd_in.col       = col;
    cmd_in.newline   = (char_code == NEWLINE_CODE);
    cmd_in.in_range  = ({1'b0, row} < (ROW_W+1)'(ROWS)) && ({1'b0, col} < (COL_W+1)'(COLUMNS));
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= cmd_in;
    end
  end

  // Pointers wrap naturally as the depth is a power of two
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ design/tcw_back.sv @@
// Back end: cell store, cursor, scroll and clear sweeps, result generation.
module tcw_back
  import tcw_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic [ATTR_W-1:0] char_color,
  input  logic              inverse_blank_mode,
  input  logic              cmd_empty,
  input  cmd_t              cmd_head,
  output logic              cmd_pop,
  input  logic              res_full,
  output logic              res_push,
  output res_t              res_data,
  output logic              initialising
);

  localparam logic [2:0] S_INIT   = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_EXEC   = 3'd2;
  localparam logic [2:0] S_RDWAIT = 3'd3;
  localparam logic [2:0] S_CLEAR  = 3'd4;
  localparam logic [2:0] S_SCROLL = 3'd5;
  localparam logic [2:0] S_RESULT = 3'd6;

  logic [CELL_W-1:0] mem [CELLS];
  logic [CELL_W-1:0] rdata;

  logic [2:0]        state;
  cmd_t              cmd;
  logic [COL_W-1:0]  cur_col;
  logic [ROW_W-1:0]  cur_row;
  logic [TOP_W-1:0]  top_line;
  logic [ADDR_W-1:0] sweep_addr;
  logic [ADDR_W-1:0] sweep_end;
  logic [CELL_W-1:0] read_value;
  logic              scrolled;

  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [CELL_W-1:0] wdata;
  logic [ADDR_W-1:0] raddr;
  logic [CELL_W-1:0] blank;
  logic [COL_W:0]    exec_col;
  logic [ROW_W:0]    exec_row;
  logic              exec_scroll;
  logic [ADDR_W-1:0] top_base;

  // Physical address of a visible cell in the ring of rows
  function automatic logic [ADDR_W-1:0] phys_addr(
    input logic [TOP_W-1:0] top,
    input logic [ROW_W-1:0] vrow,
    input logic [COL_W-1:0] vcol
  );
    logic [ROW_W:0] prow;
    prow = (ROW_W+1)'(top) + (ROW_W+1)'(vrow);
    if (prow >= (ROW_W+1)'(ROWS)) begin
      prow = prow - (ROW_W+1)'(ROWS);
    end
    return ADDR_W'(prow * COLUMNS) + ADDR_W'(vcol);
  endfunction

  assign initialising = (state == S_INIT);
  assign cmd_pop      = (state == S_IDLE) && !cmd_empty;
  assign res_push     = (state == S_RESULT) && !res_full;
  assign blank        = {(inverse_blank_mode ? BLANK_INVERSE : BLANK_NORMAL), SPACE_CODE};
  assign top_base     = ADDR_W'(top_line * COLUMNS);

  // Cursor advance for a put
  always_comb begin
    if (cmd.newline) begin
      exec_col = '0;
      exec_row = {1'b0, cur_row} + 1'b1;
    end else begin
      exec_col = {1'b0, cur_col} + 1'b1;
      exec_row = {1'b0, cur_row};
    end
    if (exec_col >= (COL_W+1)'(COLUMNS)) begin
      exec_col = '0;
      exec_row = exec_row + 1'b1;
    end
    exec_scroll = (exec_row >= (ROW_W+1)'(ROWS));
  end

  // Store port control
  always_comb begin
    we    = 1'b0;
    waddr = sweep_addr;
    wdata = blank;
    raddr = phys_addr(top_line, cmd.row, cmd.col);
    case (state)
      S_INIT: begin
        // Reset content is always the default-colour blank
        we    = 1'b1;
        wdata = {BLANK_NORMAL, SPACE_CODE};
      end
      S_CLEAR, S_SCROLL: begin
        we = 1'b1;
      end
      S_EXEC: begin
        if (cmd.op == OP_PUT && !cmd.newline) begin
          we    = 1'b1;
          waddr = phys_addr(top_line, cur_row, cur_col);
          wdata = {char_color, cmd.char_code};
        end
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_comb begin
    res_data.cursor_col    = cur_col;
    res_data.cursor_row    = cur_row;
    res_data.cursor_offset = OFF_W'(cur_row * COLUMNS) + OFF_W'(cur_col);
    res_data.cell_value    = read_value;
    res_data.scrolled      = scrolled;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      cur_col    <= '0;
      cur_row    <= '0;
      top_line   <= '0;
      sweep_addr <= '0;
      sweep_end  <= ADDR_W'(CELLS - 1);
    end else begin
      case (state)
        S_INIT: begin
          sweep_addr <= sweep_addr + 1'b1;
          if (sweep_addr == sweep_end) begin
            state <= S_IDLE;
          end
        end
        S_CLEAR, S_SCROLL: begin
          sweep_addr <= sweep_addr + 1'b1;
          if (sweep_addr == sweep_end) begin
            state <= S_RESULT;
          end
        end
        S_IDLE: begin
          if (!cmd_empty) begin
            cmd   <= cmd_head;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          read_value <= '0;
          scrolled   <= 1'b0;
          case (cmd.op)
            OP_PUT: begin
              cur_col  <= COL_W'(exec_col);
              scrolled <= exec_scroll;
              if (exec_scroll) begin
                // Blank the old top row, which becomes the new bottom row
                cur_row    <= ROW_W'(ROWS - 1);
                top_line   <= (top_line == TOP_W'(ROWS - 1)) ? '0 : top_line + 1'b1;
                sweep_addr <= top_base;
                sweep_end  <= top_base + ADDR_W'(COLUMNS - 1);
                state      <= S_SCROLL;
              end else begin
                cur_row <= ROW_W'(exec_row);
                state   <= S_RESULT;
              end
            end
            OP_CLEAR: begin
              cur_col    <= '0;
              cur_row    <= '0;
              top_line   <= '0;
              sweep_addr <= '0;
              sweep_end  <= ADDR_W'(CELLS - 1);
              state      <= S_CLEAR;
            end
            OP_READ: begin
              state <= cmd.in_range ? S_RDWAIT : S_RESULT;
            end
            default: begin
              state <= S_RESULT;
            end
          endcase
        end
        S_RDWAIT: begin
          read_value <= rdata;
          state      <= S_RESULT;
        end
        S_RESULT: begin
          if (!res_full) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ design/tcw_out_queue.sv @@
// Result queue between the back end and the output ports.
module tcw_out_queue
  import tcw_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic res_push,
  input  res_t res_data,
  output logic res_full,
  input  logic pop,
  output logic empty,
  output res_t head
);

  res_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign res_full = (count == QCNT_W'(QDEPTH));
  assign empty    = (count == '0);
  assign head     = slots[rd_ptr];
  assign do_push  = res_push && !res_full;
  assign do_pop   = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= res_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ design/text_console_writer_top.sv @@
// Top level of the text console writer: ports, configuration registers, front/back wiring.
// Flow: a put's result reaches the output ports through the queue, execute and result
//   steps; an in-range read adds a wait state for the registered store read; a scrolling
//   put adds a sweep of one row and a clear a sweep of the whole store, one store write per cycle.
// Order: the back-end sequencer pops a new command only after the last result is pushed.
// Reset: synchronous; afterwards full stays high while the store is swept with
//   default-colour blanks; configuration writes are taken throughout.
module text_console_writer_top
  import tcw_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // Input transactions
  input  logic                 push,
  output logic                 full,
  input  logic [OP_W-1:0]      op,
  input  logic [CHAR_W-1:0]    char_code,
  input  logic [ROW_W-1:0]     row,
  input  logic [COL_W-1:0]     col,
  // Result transactions
  output logic                 empty,
  input  logic                 pop,
  output logic [COL_W-1:0]     cursor_col,
  output logic [ROW_W-1:0]     cursor_row,
  output logic [OFF_W-1:0]     cursor_offset,
  output logic [CELL_W-1:0]    cell_value,
  output logic                 scrolled,
  // Configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ATTR_W-1:0]    cfg_data
);

  logic [ATTR_W-1:0] char_color;
  logic              inverse_blank_mode;
  logic              cmd_pop;
  logic              cmd_empty;
  cmd_t              cmd_head;
  logic              res_push;
  logic              res_full;
  res_t              res_data;
  res_t              res_head;
  logic              initialising;

  // Registers are always writable; unknown indexes are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      char_color         <= COLOR_RESET;
      inverse_blank_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_CHAR_COLOR: begin
          char_color <= cfg_data;
        end
        CFG_INVERSE: begin
          inverse_blank_mode <= cfg_data[0];
        end
        default: begin
          char_color <= char_color;
        end
      endcase
    end
  end

  // Front: hold off new transactions while the store is still being swept after reset
  tcw_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .hold      (initialising),
    .full      (full),
    .op        (op),
    .char_code (char_code),
    .row       (row),
    .col       (col),
    .cmd_pop   (cmd_pop),
    .cmd_empty (cmd_empty),
    .cmd_head  (cmd_head)
  );

  // Back: executes one command at a time against the cell store
  tcw_back u_back (
    .clk                (clk),
    .rst                (rst),
    .char_color         (char_color),
    .inverse_blank_mode (inverse_blank_mode),
    .cmd_empty          (cmd_empty),
    .cmd_head           (cmd_head),
    .cmd_pop            (cmd_pop),
    .res_full           (res_full),
    .res_push           (res_push),
    .res_data           (res_data),
    .initialising       (initialising)
  );

  // Output queue: advance the back end while a finished result waits to be taken
  tcw_out_queue u_out_queue (
    .clk      (clk),
    .rst      (rst),
    .res_push (res_push),
    .res_data (res_data),
    .res_full (res_full),
    .pop      (pop),
    .empty    (empty),
    .head     (res_head)
  );

  assign cursor_col    = res_head.cursor_col;
  assign cursor_row    = res_head.cursor_row;
  assign cursor_offset = res_head.cursor_offset;
  assign cell_value    = res_head.cell_value;
  assign scrolled      = res_head.scrolled;

endmodule

@@ tb/tcw_console_checker.sv @@
// Checker for the text console writer: mirrors the screen and compares every result transaction.
module tcw_console_checker
  import tcw_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  logic                 full,
  input  logic [OP_W-1:0]      op,
  input  logic [CHAR_W-1:0]    char_code,
  input  logic [ROW_W-1:0]     row,
  input  logic [COL_W-1:0]     col,
  input  logic                 empty,
  input  logic                 pop,
  input  logic [COL_W-1:0]     cursor_col,
  input  logic [ROW_W-1:0]     cursor_row,
  input  logic [OFF_W-1:0]     cursor_offset,
  input  logic [CELL_W-1:0]    cell_value,
  input  logic                 scrolled,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ATTR_W-1:0]    cfg_data,
  output int                   mismatch_count,
  output int                   results_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // Screen mirror held as a ring of rows, as the block keeps it
  logic [CELL_W-1:0] screen_mirror [CELLS];
  int                col_now;
  int                row_now;
  int                top_row;
  logic [ATTR_W-1:0] ink_color;
  logic              blank_inverse;
  res_t              awaited_q [$];
  int                fail_tally = 0;

  assign mismatch_count = fail_tally;

  function automatic logic [CELL_W-1:0] blank_cell();
    return {blank_inverse ? BLANK_INVERSE : BLANK_NORMAL, SPACE_CODE};
  endfunction

  function automatic int cell_index(int vrow, int vcol);
    return ((top_row + vrow) % ROWS) * COLUMNS + vcol;
  endfunction

  task automatic blank_screen();
    logic [CELL_W-1:0] fill;
    fill = blank_cell();
    for (int i = 0; i < CELLS; i++) screen_mirror[i] = fill;
    col_now = 0;
    row_now = 0;
    top_row = 0;
  endtask

  // Advance the mirror by one command and work out the result it must give
  task automatic apply_command(input logic [OP_W-1:0] op_code, input logic [CHAR_W-1:0] ch,
                               input logic [ROW_W-1:0] rd_row, input logic [COL_W-1:0] rd_col,
                               output res_t res);
    logic [CELL_W-1:0] read_value;
    logic [CELL_W-1:0] fill;
    logic              scroll_hit;
    int                base;
    read_value = '0;
    scroll_hit = 1'b0;
    case (op_code)
      OP_PUT: begin
        if (ch == NEWLINE_CODE) begin
          col_now = 0;
          row_now++;
        end else begin
          screen_mirror[cell_index(row_now, col_now)] = {ink_color, ch};
          col_now++;
        end
        if (col_now >= COLUMNS) begin
          col_now = 0;
          row_now++;
        end
        if (row_now >= ROWS) begin
          // old top row turns into the new, blank bottom row
          fill = blank_cell();
          base = top_row * COLUMNS;
          for (int x = 0; x < COLUMNS; x++) screen_mirror[base + x] = fill;
          top_row = (top_row + 1) % ROWS;
          row_now = ROWS - 1;
          scroll_hit = 1'b1;
        end
      end
      OP_CLEAR: blank_screen();
      OP_READ: begin
        if (rd_row < ROWS && rd_col < COLUMNS)
          read_value = screen_mirror[cell_index(rd_row, rd_col)];
      end
      default: ;
    endcase
    res.cursor_col    = COL_W'(col_now);
    res.cursor_row    = ROW_W'(row_now);
    res.cursor_offset = OFF_W'(row_now * COLUMNS + col_now);
    res.cell_value    = read_value;
    res.scrolled      = scroll_hit;
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s expected 0x%0h, actual 0x%0h", $time, name, want, got);
      fail_tally++;
    end
  endtask

  always @(posedge clk) begin : monitor
    res_t want;
    if (rst) begin
      ink_color = COLOR_RESET;
      blank_inverse = 1'b0;
      blank_screen();
      awaited_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_CHAR_COLOR: ink_color = cfg_data;
          CFG_INVERSE:    blank_inverse = cfg_data[0];
          default: ;
        endcase
      end
      if (pop && !empty) begin
        if (awaited_q.size() == 0) begin
          $display("%0t: result transaction expected none, actual col %0d row %0d cell 0x%0h",
                   $time, cursor_col, cursor_row, cell_value);
          fail_tally++;
        end else begin
          want = awaited_q.pop_front();
          check_field("cursor_col", want.cursor_col, cursor_col);
          check_field("cursor_row", want.cursor_row, cursor_row);
          check_field("cursor_offset", want.cursor_offset, cursor_offset);
          check_field("cell_value", want.cell_value, cell_value);
          check_field("scrolled", want.scrolled, scrolled);
        end
      end
      if (push && !full) begin
        apply_command(op, char_code, row, col, want);
        awaited_q.push_back(want);
      end
    end
    results_pending <= awaited_q.size();
  end

endmodule

@@ tb/tb_text_console_writer_top.sv @@
// Testbench top for the text console writer: stimulus, flow control and the verdict.
module tb_text_console_writer_top;
  import tcw_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int RESET_CYCLES  = 9;
  localparam int ITEM_TARGET   = 1050;
  localparam int SETTLE_CYCLES = 40;
  localparam int DRAIN_CYCLES  = 50;
  // long receiver hold-off: length and the item counts at which it kicks in
  localparam int LONG_HOLD     = 300;
  localparam int FIRST_HOLD_AT = 250;
  localparam int HOLD_SPACING  = 370;

  // codes the block must shrug off
  localparam logic [OP_W-1:0]      OP_UNUSED      = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_3 = 2'd3;

  logic                 clk;
  logic                 rst;
  logic                 push;
  logic                 full;
  logic [OP_W-1:0]      op;
  logic [CHAR_W-1:0]    char_code;
  logic [ROW_W-1:0]     row;
  logic [COL_W-1:0]     col;
  logic                 empty;
  logic                 pop;
  logic [COL_W-1:0]     cursor_col;
  logic [ROW_W-1:0]     cursor_row;
  logic [OFF_W-1:0]     cursor_offset;
  logic [CELL_W-1:0]    cell_value;
  logic                 scrolled;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [ATTR_W-1:0]    cfg_data;
  int                   mismatch_count;
  int                   results_pending;

  // calm: no idling on either side; set only at a rising edge so the
  // receiver, which acts on falling edges, never races it
  bit calm;
  int items_sent;
  int steady_items;
  int cycle_count;

  text_console_writer_top u_top (.*);
  tcw_console_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: end the run if it overstays the cycle budget
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Offer one command transaction and hold it until accepted. Before it, now and
  // then drop push for a gap, unless the run is calm or a steady stretch is running.
  // Called and returning at a falling edge, so push changes once per step at most.
  task automatic send_item(input logic [OP_W-1:0] o, input logic [CHAR_W-1:0] ch,
                           input logic [ROW_W-1:0] r, input logic [COL_W-1:0] c);
    int gap;
    if (!calm) begin
      if (steady_items > 0) begin
        steady_items--;
      end else if ($urandom_range(0, 9) == 0) begin
        steady_items = $urandom_range(10, 50);
      end else if ($urandom_range(0, 2) == 0) begin
        gap = $urandom_range(1, 8);
        push <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    push      <= 1'b1;
    op        <= o;
    char_code <= ch;
    row       <= r;
    col       <= c;
    do @(posedge clk); while (full);
    items_sent++;
    @(negedge clk);
  endtask

  // Write one register; valid stays up so back-to-back writes follow without it dropping.
  // The caller drops cfg_valid after the last write of a group.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ATTR_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  // Drain the block between phases: stop pushing, wait for every result, set calm if
  // asked, then wait out SETTLE_CYCLES; each row sweep ends before its result is given.
  task automatic settle(input bit go_calm);
    push <= 1'b0;
    while (results_pending != 0) @(posedge clk);
    if (go_calm) calm = 1'b1;
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Random traffic up to a running item count. Most of it is text: lines of
  // printable characters, short as a rule and now and then long enough to wrap,
  // each closed by a newline; runs of newlines push the screen into scrolling.
  // Reads probe the screen, with the odd one out of range; unused ops and clears
  // are sprinkled in as noise.
  task automatic run_random(input int upto);
    int                kind;
    int                len;
    logic [CHAR_W-1:0] ch;
    logic [ROW_W-1:0]  r;
    logic [COL_W-1:0]  c;
    while (items_sent < upto) begin
      kind = $urandom_range(0, 99);
      if (kind < 60) begin
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 170) : $urandom_range(0, 20);
        for (int i = 0; i < len; i++) begin
          // mostly printable; sometimes any byte, high half and control codes too
          ch = ($urandom_range(0, 7) == 0) ? CHAR_W'($urandom_range(0, 255))
                                          : CHAR_W'($urandom_range(8'h20, 8'h7E));
          send_item(OP_PUT, ch, ROW_W'($urandom), COL_W'($urandom));
        end
        send_item(OP_PUT, NEWLINE_CODE, ROW_W'($urandom), COL_W'($urandom));
      end else if (kind < 85) begin
        len = $urandom_range(1, 4);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 7) == 0) begin
            r = ROW_W'($urandom);
            c = COL_W'($urandom);
          end else begin
            r = ROW_W'($urandom_range(0, ROWS - 1));
            c = COL_W'($urandom_range(0, COLUMNS - 1));
          end
          send_item(OP_READ, CHAR_W'($urandom), r, c);
        end
      end else if (kind < 90) begin
        send_item(OP_UNUSED, CHAR_W'($urandom), ROW_W'($urandom), COL_W'($urandom));
      end else if (kind < 93) begin
        send_item(OP_CLEAR, CHAR_W'($urandom), ROW_W'($urandom), COL_W'($urandom));
      end else begin
        len = $urandom_range(1, 30);
        for (int i = 0; i < len; i++)
          send_item(OP_PUT, NEWLINE_CODE, ROW_W'($urandom), COL_W'($urandom));
      end
    end
  endtask

  // Result side: pop with random stall bursts and steady stretches, one long
  // hold-off per marked point so the block backs up and stalls its input,
  // and a constant pop once the run goes calm
  initial begin : result_side
    int stall_left;
    int quiet_left;
    int hold_mark;
    pop = 1'b0;
    stall_left = 0;
    quiet_left = 0;
    hold_mark = FIRST_HOLD_AT;
    forever begin
      @(negedge clk);
      if (calm) begin
        pop <= 1'b1;
      end else if (items_sent >= hold_mark) begin
        hold_mark += HOLD_SPACING;
        pop <= 1'b0;
        for (int i = 0; i < LONG_HOLD; i++) @(negedge clk);
      end else if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else if (quiet_left > 0) begin
        quiet_left--;
        pop <= 1'b1;
      end else begin
        case ($urandom_range(0, 5))
          0, 1: begin
            stall_left = $urandom_range(0, 7);
            pop <= 1'b0;
          end
          2: begin
            quiet_left = $urandom_range(10, 60);
            pop <= 1'b1;
          end
          default: pop <= 1'b1;
        endcase
      end
    end
  end

  initial begin : stimulus
    rst          = 1'b1;
    push         = 1'b0;
    op           = OP_PUT;
    char_code    = '0;
    row          = '0;
    col          = '0;
    cfg_valid    = 1'b0;
    cfg_index    = CFG_CHAR_COLOR;
    cfg_data     = '0;
    calm         = 1'b0;
    items_sent   = 0;
    steady_items = 0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;

    // Directed part, reset configuration. The block sweeps its store after
    // reset with full held high; the first transaction simply waits for it.
    // Reset content: both corner cells are blanks in the default colour
    send_item(OP_READ, 8'h00, 5'd0, 7'd0);
    send_item(OP_READ, 8'h00, ROW_W'(ROWS - 1), COL_W'(COLUMNS - 1));
    // Reads out of range give zero: row past the end, both fields at all ones, column past
    send_item(OP_READ, 8'h00, ROW_W'(ROWS), 7'd0);
    send_item(OP_READ, 8'hFF, 5'h1F, 7'h7F);
    send_item(OP_READ, 8'h00, 5'd0, COL_W'(COLUMNS));
    // Bytes with the top bit set must not bleed into the attribute
    send_item(OP_PUT, 8'h41, 5'd0, 7'd0);
    send_item(OP_PUT, 8'h80, 5'd0, 7'd0);
    send_item(OP_PUT, 8'hFF, 5'h1F, 7'h7F);
    send_item(OP_PUT, 8'h00, 5'd0, 7'd0);
    send_item(OP_READ, 8'h00, 5'd0, 7'd1);
    send_item(OP_READ, 8'h00, 5'd0, 7'd2);
    // Unused op: nothing moves, cursor reported as is
    send_item(OP_UNUSED, 8'hFF, 5'h1F, 7'h7F);
    send_item(OP_PUT, NEWLINE_CODE, 5'd0, 7'd0);
    send_item(OP_PUT, 8'h7F, 5'd0, 7'd0);
    send_item(OP_READ, 8'h00, 5'd1, 7'd0);
    // Clear homes the cursor and blanks what was written
    send_item(OP_CLEAR, 8'h00, 5'd0, 7'd0);
    send_item(OP_READ, 8'h00, 5'd0, 7'd0);
    send_item(OP_READ, 8'h00, 5'd1, 7'd0);
    send_item(OP_PUT, SPACE_CODE, 5'd0, 7'd0);

    run_random(180);

    // Brightest attribute, inverse blanks
    settle(1'b0);
    write_reg(CFG_CHAR_COLOR, 8'hFF);
    write_reg(CFG_INVERSE, 8'h01);
    cfg_valid <= 1'b0;
    run_random(360);

    // Zero attribute; only bit 0 of the blank mode counts, and the spare
    // indexes must change nothing
    settle(1'b0);
    write_reg(CFG_CHAR_COLOR, 8'h00);
    write_reg(CFG_INVERSE, 8'hFE);
    write_reg(CFG_UNMAPPED_2, 8'hAA);
    write_reg(CFG_UNMAPPED_3, 8'h55);
    cfg_valid <= 1'b0;
    run_random(540);

    settle(1'b0);
    write_reg(CFG_CHAR_COLOR, ATTR_W'($urandom));
    write_reg(CFG_INVERSE, ATTR_W'($urandom) | 8'h01);
    cfg_valid <= 1'b0;
    run_random(720);

    settle(1'b0);
    write_reg(CFG_CHAR_COLOR, ATTR_W'($urandom));
    write_reg(CFG_INVERSE, ATTR_W'($urandom));
    cfg_valid <= 1'b0;
    run_random(880);

    // Last stretch at full rate with no idling on either side
    settle(1'b1);
    write_reg(CFG_CHAR_COLOR, COLOR_RESET);
    write_reg(CFG_INVERSE, ATTR_W'($urandom));
    cfg_valid <= 1'b0;
    run_random(ITEM_TARGET);

    // Wait out the last results, then a margin to catch any stray transaction
    push <= 1'b0;
    while (results_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/tcw_pkg.sv
design/tcw_front.sv
design/tcw_back.sv
design/tcw_out_queue.sv
design/text_console_writer_top.sv
tb/tcw_console_checker.sv
tb/tb_text_console_writer_top.sv
